### hw/rtl/ssg_pkg.sv
// Shared types and codes for the scatter schedule generator.
// Used by the channel interfaces, the sequencer and the top level.
`default_nettype none

package ssg_pkg;

    // Field widths
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;
    localparam int BYTES_W = 24;
    localparam int OFF_W   = 30;
    localparam int MODE_W  = 2;
    localparam int CODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Auto mode switches to the linear scheme at this block size
    localparam logic [BYTES_W-1:0] SMALL_LIMIT = 24'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALG_MODE    = 2'd2;

    // Algorithm modes
    localparam logic [MODE_W-1:0] MODE_AUTO     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINOMIAL = 2'd2;

    // Entry actions
    localparam logic [CODE_W-1:0] ACT_RECV = 2'd0;
    localparam logic [CODE_W-1:0] ACT_SEND = 2'd1;
    localparam logic [CODE_W-1:0] ACT_COPY = 2'd2;
    localparam logic [CODE_W-1:0] ACT_NONE = 2'd3;

    // Buffer areas
    localparam logic [CODE_W-1:0] AREA_SEND = 2'd0;
    localparam logic [CODE_W-1:0] AREA_RECV = 2'd1;
    localparam logic [CODE_W-1:0] AREA_TEMP = 2'd2;
    localparam logic [CODE_W-1:0] AREA_NET  = 2'd3;

    // One schedule entry
    typedef struct packed {
        logic [CODE_W-1:0] action;
        logic [RANK_W-1:0] peer;
        logic [CODE_W-1:0] src_area;
        logic [OFF_W-1:0]  src_offset;
        logic [CODE_W-1:0] dst_area;
        logic [OFF_W-1:0]  dst_offset;
        logic [OFF_W-1:0]  byte_count;
        logic              barrier_after;
        logic              last;
    } t_entry;

    // Entry handed from the sequencer to the output register
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

endpackage

`default_nettype wire

### hw/rtl/ssg_if.sv
// Valid/ready channel interfaces: request words in, schedule entry words out.
// Depends on ssg_pkg for field widths.
`default_nettype none

interface ssg_req_if;
    import ssg_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] my_rank;
    logic [RANK_W-1:0] root_rank;
    logic              in_place;

    modport source (output valid, output my_rank, output root_rank, output in_place,
                    input ready);
    modport sink   (input valid, input my_rank, input root_rank, input in_place,
                    output ready);
endinterface

interface ssg_entry_if;
    import ssg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] action;
    logic [RANK_W-1:0] peer;
    logic [CODE_W-1:0] src_area;
    logic [OFF_W-1:0]  src_offset;
    logic [CODE_W-1:0] dst_area;
    logic [OFF_W-1:0]  dst_offset;
    logic [OFF_W-1:0]  byte_count;
    logic              barrier_after;
    logic              last;

    modport source (output valid, output action, output peer, output src_area,
                    output src_offset, output dst_area, output dst_offset,
                    output byte_count, output barrier_after, output last,
                    input ready);
    modport sink   (input valid, input action, input peer, input src_area,
                    input src_offset, input dst_area, input dst_offset,
                    input byte_count, input barrier_after, input last,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/ssg_mul.sv
// Shared multiplier: rank count times block bytes, registered product.
// Depends on ssg_pkg for widths.
`default_nettype none

module ssg_mul (
    input  wire logic                        i_clk,
    input  wire logic [ssg_pkg::COUNT_W-1:0] i_fac,
    input  wire logic [ssg_pkg::BYTES_W-1:0] i_bytes,
    output logic      [ssg_pkg::OFF_W-1:0]   o_prod
);
    import ssg_pkg::*;

    logic [COUNT_W+BYTES_W-1:0] prod;
    logic [OFF_W-1:0]           r_prod;

    // Multiply at full width, keep the offset bits
    assign prod = {{BYTES_W{1'b0}}, i_fac} * {{COUNT_W{1'b0}}, i_bytes};

    always_ff @(posedge i_clk) begin
        r_prod <= prod[OFF_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### hw/rtl/ssg_seq.sv
// Schedule sequencer: walks the linear or binomial transfer list one entry
// at a time, drives the shared multiplier and holds one pending entry so the
// final one can carry the last mark. Depends on ssg_pkg and ssg_mul.
`default_nettype none

module ssg_seq #(
    parameter int MAX_RANKS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ssg_pkg::RANK_W-1:0]  i_my_rank,
    input  wire logic [ssg_pkg::RANK_W-1:0]  i_root_rank,
    input  wire logic                        i_in_place,
    input  wire logic [ssg_pkg::COUNT_W-1:0] i_group_size,
    input  wire logic [ssg_pkg::BYTES_W-1:0] i_block_bytes,
    input  wire logic [ssg_pkg::MODE_W-1:0]  i_mode,
    input  wire logic                        i_out_free,
    output logic                             o_idle,
    output ssg_pkg::t_push                   o_push
);
    import ssg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VIRT, S_TREE, S_CHK, S_MUL1, S_GET1, S_GET2, S_PUT, S_FLUSH
    } t_state;

    typedef enum logic [3:0] {
        K_LIN_RECV, K_LIN_ROOT, K_ROOT_COPY, K_ROOT_SH1, K_ROOT_SH2,
        K_RECV1, K_RECV2, K_CHILD1, K_CHILD2
    } t_kind;

    localparam logic [COUNT_W-1:0] P_MAX = COUNT_W'(MAX_RANKS);
    localparam logic [COUNT_W-1:0] ONE   = COUNT_W'(1);

    t_state             r_state;
    t_kind              r_kind;
    logic [RANK_W-1:0]  r_me;
    logic [RANK_W-1:0]  r_root;
    logic               r_inpl;
    logic               r_bin;
    logic [COUNT_W-1:0] r_p;
    logic [RANK_W-1:0]  r_v;
    logic [RANK_W-1:0]  r_peer;
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] r_mask;
    logic [COUNT_W-1:0] r_idx;
    logic [OFF_W-1:0]   r_off;
    logic [OFF_W-1:0]   r_prod1;
    logic [OFF_W-1:0]   r_prod2;
    t_entry             r_pend;
    logic               r_pend_vld;

    logic [COUNT_W-1:0] p_clamp;
    logic               bin_sel;
    logic [COUNT_W:0]   vt;
    logic [COUNT_W:0]   vr;
    logic [RANK_W-1:0]  vm1;
    logic [RANK_W-1:0]  vpar;
    logic [COUNT_W-1:0] par_sum;
    logic [COUNT_W-1:0] par;
    logic [COUNT_W-1:0] cnt0;
    logic [COUNT_W-1:0] cnt_sum;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] vk;
    logic               child_ok;
    logic [COUNT_W-1:0] p_left;
    logic [COUNT_W-1:0] kc;
    logic [COUNT_W-1:0] kid_sum;
    logic [COUNT_W-1:0] kid;
    logic [COUNT_W-1:0] f1;
    logic [COUNT_W-1:0] f2;
    logic [COUNT_W-1:0] fac;
    logic               two_prod;
    logic [OFF_W-1:0]   prod;
    logic [OFF_W-1:0]   bb;
    logic               emit;
    logic               go;
    t_entry             ent;
    t_entry             none_ent;

    // Shared multiplier
    ssg_mul u_mul (
        .i_clk   (i_clk),
        .i_fac   (fac),
        .i_bytes (i_block_bytes),
        .o_prod  (prod)
    );

    assign bb = {{(OFF_W-BYTES_W){1'b0}}, i_block_bytes};

    // Clamp group size and pick the scheme at request time
    always_comb begin
        if (i_group_size == '0) begin
            p_clamp = ONE;
        end else if (i_group_size > P_MAX) begin
            p_clamp = P_MAX;
        end else begin
            p_clamp = i_group_size;
        end
        case (i_mode)
            MODE_LINEAR:   bin_sel = 1'b0;
            MODE_BINOMIAL: bin_sel = 1'b1;
            default:       bin_sel = (i_block_bytes < SMALL_LIMIT);
        endcase
    end

    // Virtual rank: (me + p - root) mod p, one subtract step
    assign vt = {2'b00, r_me} + {1'b0, r_p} - {2'b00, r_root};
    assign vr = (vt >= {1'b0, r_p}) ? vt - {1'b0, r_p} : vt;

    // Parent and subtree count
    assign vm1     = r_v - RANK_W'(1);
    assign vpar    = r_v & vm1;
    assign par_sum = {1'b0, vpar} + {1'b0, r_root};
    assign par     = (par_sum >= r_p) ? par_sum - r_p : par_sum;
    assign cnt0    = {1'b0, r_v} - {1'b0, vpar};
    assign cnt_sum = cnt0 + {1'b0, r_v};
    assign cnt     = (cnt_sum >= r_p) ? r_p - {1'b0, r_v} : cnt0;

    // Next child round
    assign vk       = {1'b0, r_v} | r_mask;
    assign child_ok = (({1'b0, r_v} & r_mask) == '0) && (vk < r_p);
    assign p_left   = r_p - vk;
    assign kc       = (r_mask > p_left) ? p_left : r_mask;
    assign kid_sum  = vk + {1'b0, r_root};
    assign kid      = (kid_sum >= r_p) ? kid_sum - r_p : kid_sum;

    // Multiplier factors per entry kind
    always_comb begin
        f2       = '0;
        two_prod = 1'b0;
        case (r_kind)
            K_LIN_ROOT:  f1 = r_idx;
            K_ROOT_COPY: f1 = {1'b0, r_root};
            K_ROOT_SH1: begin
                f1       = r_p - ONE - {1'b0, r_root};
                f2       = {1'b0, r_root};
                two_prod = 1'b1;
            end
            K_ROOT_SH2: begin
                f1       = {1'b0, r_root} + ONE;
                f2       = r_p - ONE - {1'b0, r_root};
                two_prod = 1'b1;
            end
            K_RECV2:     f1 = r_cnt - ONE;
            K_CHILD2:    f1 = r_cnt - ONE;
            default:     f1 = ONE;
        endcase
        fac = (r_state == S_GET1) ? f2 : f1;
    end

    // Form the entry of the current kind
    always_comb begin
        none_ent        = '0;
        none_ent.action = ACT_NONE;
        none_ent.last   = 1'b1;

        ent      = '0;
        emit     = 1'b1;
        case (r_kind)
            K_LIN_RECV: begin
                ent.action     = ACT_RECV;
                ent.peer       = r_root;
                ent.src_area   = AREA_NET;
                ent.dst_area   = AREA_RECV;
                ent.byte_count = bb;
            end
            K_LIN_ROOT: begin
                ent.src_area   = AREA_SEND;
                ent.src_offset = r_prod1;
                ent.byte_count = bb;
                if (r_idx == {1'b0, r_root}) begin
                    ent.action   = ACT_COPY;
                    ent.dst_area = AREA_RECV;
                    emit         = !r_inpl;
                end else begin
                    ent.action   = ACT_SEND;
                    ent.peer     = r_idx[RANK_W-1:0];
                    ent.dst_area = AREA_NET;
                end
            end
            K_ROOT_COPY: begin
                ent.action     = ACT_COPY;
                ent.src_area   = AREA_SEND;
                ent.src_offset = r_prod1;
                ent.dst_area   = AREA_RECV;
                ent.byte_count = bb;
            end
            K_ROOT_SH1: begin
                ent.action     = ACT_COPY;
                ent.src_area   = AREA_SEND;
                ent.dst_area   = AREA_TEMP;
                ent.dst_offset = r_prod1;
                ent.byte_count = r_prod2;
            end
            K_ROOT_SH2: begin
                ent.action        = ACT_COPY;
                ent.src_area      = AREA_SEND;
                ent.src_offset    = r_prod1;
                ent.dst_area      = AREA_TEMP;
                ent.byte_count    = r_prod2;
                ent.barrier_after = 1'b1;
            end
            K_RECV1: begin
                ent.action     = ACT_RECV;
                ent.peer       = r_peer;
                ent.src_area   = AREA_NET;
                ent.dst_area   = AREA_RECV;
                ent.byte_count = bb;
            end
            K_RECV2: begin
                ent.action        = ACT_RECV;
                ent.peer          = r_peer;
                ent.src_area      = AREA_NET;
                ent.dst_area      = AREA_TEMP;
                ent.byte_count    = r_prod1;
                ent.barrier_after = 1'b1;
            end
            K_CHILD1: begin
                ent.action     = ACT_SEND;
                ent.peer       = r_peer;
                ent.src_area   = AREA_TEMP;
                ent.src_offset = r_off;
                ent.dst_area   = AREA_NET;
                ent.byte_count = bb;
            end
            K_CHILD2: begin
                ent.action     = ACT_SEND;
                ent.peer       = r_peer;
                ent.src_area   = AREA_TEMP;
                ent.src_offset = r_off;
                ent.dst_area   = AREA_NET;
                ent.byte_count = r_prod1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Pending entry moves out when the next one arrives; flush marks last
    assign go = !emit || !r_pend_vld || i_out_free;

    always_comb begin
        o_push.valid = 1'b0;
        o_push.entry = r_pend;
        if (r_state == S_PUT) begin
            o_push.valid = emit && r_pend_vld && i_out_free;
        end else if (r_state == S_FLUSH) begin
            o_push.valid = i_out_free;
            if (r_pend_vld) begin
                o_push.entry.last = 1'b1;
            end else begin
                o_push.entry = none_ent;
            end
        end
    end

    assign o_idle = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_kind     <= K_LIN_RECV;
            r_pend_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_me    <= i_my_rank;
                        r_root  <= i_root_rank;
                        r_inpl  <= i_in_place;
                        r_p     <= p_clamp;
                        r_bin   <= bin_sel;
                        r_state <= S_VIRT;
                    end
                end
                S_VIRT: begin
                    r_v    <= vr[RANK_W-1:0];
                    r_mask <= ONE;
                    r_off  <= '0;
                    r_idx  <= '0;
                    if (({1'b0, r_me} >= r_p) || ({1'b0, r_root} >= r_p)) begin
                        r_state <= S_FLUSH;
                    end else if (r_bin) begin
                        r_state <= S_TREE;
                    end else begin
                        r_kind  <= (r_me != r_root) ? K_LIN_RECV : K_LIN_ROOT;
                        r_state <= S_MUL1;
                    end
                end
                S_TREE: begin
                    if (r_v == '0) begin
                        r_kind <= r_inpl ? K_ROOT_SH1 : K_ROOT_COPY;
                    end else begin
                        r_kind <= K_RECV1;
                        r_peer <= par[RANK_W-1:0];
                        r_cnt  <= cnt;
                    end
                    r_state <= S_MUL1;
                end
                S_CHK: begin
                    if (child_ok) begin
                        r_kind  <= K_CHILD1;
                        r_peer  <= kid[RANK_W-1:0];
                        r_cnt   <= kc;
                        r_state <= S_MUL1;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_MUL1: begin
                    r_state <= S_GET1;
                end
                S_GET1: begin
                    r_prod1 <= prod;
                    r_state <= two_prod ? S_GET2 : S_PUT;
                end
                S_GET2: begin
                    r_prod2 <= prod;
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (go) begin
                        if (emit) begin
                            r_pend     <= ent;
                            r_pend_vld <= 1'b1;
                        end
                        case (r_kind)
                            K_LIN_RECV: r_state <= S_FLUSH;
                            K_LIN_ROOT: begin
                                if (r_idx + ONE < r_p) begin
                                    r_idx   <= r_idx + ONE;
                                    r_state <= S_MUL1;
                                end else begin
                                    r_state <= S_FLUSH;
                                end
                            end
                            K_ROOT_COPY: begin
                                r_kind  <= K_ROOT_SH1;
                                r_state <= S_MUL1;
                            end
                            K_ROOT_SH1: begin
                                r_kind  <= K_ROOT_SH2;
                                r_state <= S_MUL1;
                            end
                            K_RECV1: begin
                                if (r_cnt > ONE) begin
                                    r_kind  <= K_RECV2;
                                    r_state <= S_MUL1;
                                end else begin
                                    r_state <= S_CHK;
                                end
                            end
                            K_CHILD1: begin
                                r_off <= r_off + bb;
                                if (r_cnt > ONE) begin
                                    r_kind  <= K_CHILD2;
                                    r_state <= S_MUL1;
                                end else begin
                                    r_mask  <= {r_mask[COUNT_W-2:0], 1'b0};
                                    r_state <= S_CHK;
                                end
                            end
                            K_CHILD2: begin
                                r_off   <= r_off + r_prod1;
                                r_mask  <= {r_mask[COUNT_W-2:0], 1'b0};
                                r_state <= S_CHK;
                            end
                            default: r_state <= S_CHK;
                        endcase
                    end
                end
                S_FLUSH: begin
                    if (i_out_free) begin
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/scatter_schedule_generator.sv
// Scatter schedule generator: takes one request word (own rank, root rank,
// in-place flag) and emits this node's transfer list as a run of entry
// words, the final one marked last; a request with no transfers gives one
// none entry. Group size, block bytes and algorithm mode are to be written on the
// configuration port only while the block is idle; the block does not enforce
// this. Requests are taken one at a time: every entry passes through a single
// shared multiplier, stepping through S_MUL1, S_GET1 and S_PUT (S_GET2 too for
// the root's two shift copies, which need two products); setup uses S_VIRT and,
// for the binomial scheme, S_TREE, each child round is checked in S_CHK and
// S_FLUSH ends the list. Stalls on the entry channel hold S_PUT and S_FLUSH.
// Depends on ssg_pkg, ssg_if, ssg_mul and ssg_seq.
`default_nettype none

module scatter_schedule_generator #(
    parameter int MAX_RANKS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ssg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ssg_pkg::BYTES_W-1:0]   i_cfg_data,
    ssg_req_if.sink                            i_req,
    ssg_entry_if.source                        o_entry
);
    import ssg_pkg::*;

    logic [COUNT_W-1:0] r_group_size;
    logic [BYTES_W-1:0] r_block_bytes;
    logic [MODE_W-1:0]  r_mode;
    t_entry             r_out;
    logic               r_out_vld;

    logic  idle;
    logic  out_free;
    t_push push;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size  <= COUNT_W'(1);
            r_block_bytes <= '0;
            r_mode        <= MODE_AUTO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GROUP_SIZE:  r_group_size  <= i_cfg_data[COUNT_W-1:0];
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data;
                CFG_ALG_MODE:    r_mode        <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = idle;
    assign out_free    = !r_out_vld || o_entry.ready;

    ssg_seq #(
        .MAX_RANKS (MAX_RANKS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_req.valid && idle),
        .i_my_rank     (i_req.my_rank),
        .i_root_rank   (i_req.root_rank),
        .i_in_place    (i_req.in_place),
        .i_group_size  (r_group_size),
        .i_block_bytes (r_block_bytes),
        .i_mode        (r_mode),
        .i_out_free    (out_free),
        .o_idle        (idle),
        .o_push        (push)
    );

    // Output register: load a new word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push.valid) begin
            r_out_vld <= 1'b1;
        end else if (o_entry.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out <= push.entry;
        end
    end

    assign o_entry.valid         = r_out_vld;
    assign o_entry.action        = r_out.action;
    assign o_entry.peer          = r_out.peer;
    assign o_entry.src_area      = r_out.src_area;
    assign o_entry.src_offset    = r_out.src_offset;
    assign o_entry.dst_area      = r_out.dst_area;
    assign o_entry.dst_offset    = r_out.dst_offset;
    assign o_entry.byte_count    = r_out.byte_count;
    assign o_entry.barrier_after = r_out.barrier_after;
    assign o_entry.last          = r_out.last;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for scatter_schedule_generator: a directed table followed by random requests.
// Every entry word is scored against a behavioral schedule predictor, or against a fixed word for typed rows.
// Depends on ssg_pkg, ssg_if and the scatter_schedule_generator RTL.
module tb_top;
    import ssg_pkg::*;

    localparam int MAX_RANKS      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQS     = 10;

    // The unused mode code, which the block treats as auto
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [COUNT_W-1:0] grp_size;
        logic [BYTES_W-1:0] blk_bytes;
        logic [MODE_W-1:0]  alg_mode;
        logic [RANK_W-1:0]  my_rank;
        logic [RANK_W-1:0]  root_rank;
        logic               in_place;
        logic               typed;
        t_entry             entry;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTES_W-1:0]   i_cfg_data;

    ssg_req_if   req_ch ();
    ssg_entry_if entry_ch ();

    scatter_schedule_generator #(
        .MAX_RANKS (MAX_RANKS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_entry    (entry_ch)
    );

    // Predictor's copy of the configuration
    logic [COUNT_W-1:0] cfg_group_size;
    logic [BYTES_W-1:0] cfg_block_bytes;
    logic [MODE_W-1:0]  cfg_alg_mode;

    t_entry   sched_plan[$];
    t_entry   sched_expect[$];
    t_dir_row dir_rows[$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    logic [4:0]  stall_step  = '0;
    logic [31:0] stall_pattern = '0;
    logic        stall_enable  = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic string entry_str(t_entry e);
        return $sformatf("act=%0d peer=%0d src=%0d/%0h dst=%0d/%0h bytes=%0h bar=%0b last=%0b",
                         e.action, e.peer, e.src_area, e.src_offset, e.dst_area,
                         e.dst_offset, e.byte_count, e.barrier_after, e.last);
    endfunction

    function automatic t_entry none_word();
        t_entry e;
        e        = '0;
        e.action = ACT_NONE;
        e.last   = 1'b1;
        return e;
    endfunction

    function automatic t_entry recv_word(logic [RANK_W-1:0] peer, logic [OFF_W-1:0] cnt);
        t_entry e;
        e            = '0;
        e.action     = ACT_RECV;
        e.peer       = peer;
        e.src_area   = AREA_NET;
        e.dst_area   = AREA_RECV;
        e.byte_count = cnt;
        e.last       = 1'b1;
        return e;
    endfunction

    function automatic void add_row(logic [COUNT_W-1:0] grp, logic [BYTES_W-1:0] blk,
                                    logic [MODE_W-1:0] mode, logic [RANK_W-1:0] me,
                                    logic [RANK_W-1:0] root, logic inpl, logic typed,
                                    t_entry e);
        t_dir_row r;
        r.grp_size  = grp;
        r.blk_bytes = blk;
        r.alg_mode  = mode;
        r.my_rank   = me;
        r.root_rank = root;
        r.in_place  = inpl;
        r.typed     = typed;
        r.entry     = e;
        dir_rows.push_back(r);
    endfunction

    // Append one planned entry, offsets and counts wrapped to the field width
    function automatic void plan_add(logic [CODE_W-1:0] act, longint unsigned peer,
                                     logic [CODE_W-1:0] sa, longint unsigned so,
                                     logic [CODE_W-1:0] da, longint unsigned dofs,
                                     longint unsigned cnt, logic bar);
        t_entry e;
        e.action        = act;
        e.peer          = peer[RANK_W-1:0];
        e.src_area      = sa;
        e.src_offset    = so[OFF_W-1:0];
        e.dst_area      = da;
        e.dst_offset    = dofs[OFF_W-1:0];
        e.byte_count    = cnt[OFF_W-1:0];
        e.barrier_after = bar;
        e.last          = 1'b0;
        sched_plan.push_back(e);
    endfunction

    // Work out the transfer list of one request under the current configuration
    function automatic void plan_schedule(logic [RANK_W-1:0] me_in, logic [RANK_W-1:0] root_in,
                                          logic inpl);
        longint unsigned p, me, root, b, v, vpar, par, cnt, mask, off, vk, kc, kid;
        logic binomial;
        sched_plan.delete();
        p    = cfg_group_size;
        me   = me_in;
        root = root_in;
        b    = cfg_block_bytes;
        if (p == 0) p = 1;
        if (p > MAX_RANKS) p = MAX_RANKS;
        if (cfg_alg_mode == MODE_LINEAR) binomial = 1'b0;
        else if (cfg_alg_mode == MODE_BINOMIAL) binomial = 1'b1;
        else binomial = (cfg_block_bytes < SMALL_LIMIT);

        if (me < p && root < p) begin
            if (!binomial) begin
                // Linear: leaves receive once; the root sends to the others, copying its own unless in place
                if (me != root) begin
                    plan_add(ACT_RECV, root, AREA_NET, 0, AREA_RECV, 0, b, 1'b0);
                end else begin
                    for (int i = 0; i < p; i++) begin
                        if (i == root) begin
                            if (!inpl) plan_add(ACT_COPY, 0, AREA_SEND, i * b, AREA_RECV, 0, b, 1'b0);
                        end else begin
                            plan_add(ACT_SEND, i, AREA_SEND, i * b, AREA_NET, 0, b, 1'b0);
                        end
                    end
                end
            end else begin
                v    = (me + p - root) % p;
                mask = 1;
                off  = 0;
                if (v == 0) begin
                    // Root: own block unless in place, then rotate the rest into temp in virtual order
                    if (!inpl) plan_add(ACT_COPY, 0, AREA_SEND, root * b, AREA_RECV, 0, b, 1'b0);
                    plan_add(ACT_COPY, 0, AREA_SEND, 0, AREA_TEMP, (p - 1 - root) * b,
                             root * b, 1'b0);
                    plan_add(ACT_COPY, 0, AREA_SEND, (root + 1) * b, AREA_TEMP, 0,
                             (p - 1 - root) * b, 1'b1);
                end else begin
                    // Inner node or leaf: own block, then the rest of the subtree
                    vpar = v & (v - 1);
                    par  = (vpar + root) % p;
                    cnt  = v - vpar;
                    if (cnt + v >= p) cnt = p - v;
                    plan_add(ACT_RECV, par, AREA_NET, 0, AREA_RECV, 0, b, 1'b0);
                    if (cnt > 1) plan_add(ACT_RECV, par, AREA_NET, 0, AREA_TEMP, 0,
                                          (cnt - 1) * b, 1'b1);
                end
                // One child per bit below the lowest set bit of the virtual rank, while inside the group
                while (mask <= 64 && (v & mask) == 0) begin
                    vk = v | mask;
                    if (vk >= p) break;
                    kc = mask;
                    if (kc > p - vk) kc = p - vk;
                    kid = (vk + root) % p;
                    plan_add(ACT_SEND, kid, AREA_TEMP, off, AREA_NET, 0, b, 1'b0);
                    off += b;
                    if (kc > 1) begin
                        plan_add(ACT_SEND, kid, AREA_TEMP, off, AREA_NET, 0, (kc - 1) * b, 1'b0);
                        off += (kc - 1) * b;
                    end
                    mask <<= 1;
                end
            end
        end

        if (sched_plan.size() == 0) sched_plan.push_back(none_word());
        sched_plan[sched_plan.size() - 1].last = 1'b1;
    endfunction

    // Drop valid and wait until every expected entry word has arrived
    task automatic wait_drained();
        @(negedge i_clk) req_ch.valid = 1'b0;
        while (sched_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [COUNT_W-1:0] grp, logic [BYTES_W-1:0] blk,
                                logic [MODE_W-1:0] mode);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_GROUP_SIZE;
        i_cfg_data = BYTES_W'(grp);
        @(negedge i_clk);
        i_cfg_idx  = CFG_BLOCK_BYTES;
        i_cfg_data = blk;
        @(negedge i_clk);
        i_cfg_idx  = CFG_ALG_MODE;
        i_cfg_data = BYTES_W'(mode);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        cfg_group_size  = grp;
        cfg_block_bytes = blk;
        cfg_alg_mode    = mode;
    endtask

    // Present one request word and queue its entries once it is taken
    task automatic send_request(logic [RANK_W-1:0] me, logic [RANK_W-1:0] root, logic inpl,
                                logic typed, t_entry typed_entry);
        plan_schedule(me, root, inpl);
        if (typed) begin
            sched_plan.delete();
            sched_plan.push_back(typed_entry);
        end
        @(negedge i_clk);
        req_ch.valid     = 1'b1;
        req_ch.my_rank   = me;
        req_ch.root_rank = root;
        req_ch.in_place  = inpl;
        do @(posedge i_clk); while (!req_ch.ready);
        foreach (sched_plan[k]) sched_expect.push_back(sched_plan[k]);
    endtask

    // Hold valid through a burst, then idle for a random gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap        = $urandom_range(1, 12);
            @(negedge i_clk) req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Receiver stalls on a fresh random 32-bit pattern; bit 0 stays clear to bound a stall
    always @(negedge i_clk) begin
        if (stall_step == 0) begin
            stall_pattern = $urandom() & ~32'd1;
            stall_enable  = ($urandom_range(0, 2) != 0);
        end
        entry_ch.ready = !(stall_enable && stall_pattern[stall_step]);
        stall_step     = stall_step + 5'd1;
    end

    // Score each accepted entry word against the oldest expectation
    always @(posedge i_clk) begin
        t_entry got;
        t_entry want;
        if (i_rst_n && entry_ch.valid && entry_ch.ready) begin
            got.action        = entry_ch.action;
            got.peer          = entry_ch.peer;
            got.src_area      = entry_ch.src_area;
            got.src_offset    = entry_ch.src_offset;
            got.dst_area      = entry_ch.dst_area;
            got.dst_offset    = entry_ch.dst_offset;
            got.byte_count    = entry_ch.byte_count;
            got.barrier_after = entry_ch.barrier_after;
            got.last          = entry_ch.last;
            if (sched_expect.size() == 0) begin
                error_count++;
                $display("%0t: unexpected entry word: %s", $time, entry_str(got));
            end else begin
                want = sched_expect.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: entry mismatch, expected %s", $time, entry_str(want));
                    $display("%0t:                 actual   %s", $time, entry_str(got));
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (entry_ch.valid && entry_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d entries outstanding", $time,
                     sched_expect.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [COUNT_W-1:0] grp_r;
        logic [BYTES_W-1:0] blk_r;
        logic [MODE_W-1:0]  mode_r;
        logic [RANK_W-1:0]  me_r;
        logic [RANK_W-1:0]  root_r;
        int                 p_eff;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_GROUP_SIZE;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.my_rank     = '0;
        req_ch.root_rank   = '0;
        req_ch.in_place    = 1'b0;
        cfg_group_size     = 7'd1;
        cfg_block_bytes    = '0;
        cfg_alg_mode       = MODE_AUTO;

        // Directed table: reset defaults, extremes, clamps and the degenerate cases
        add_row(7'd1, 24'd0, MODE_AUTO, 6'd0, 6'd0, 1'b0, 1'b0, '0);
        add_row(7'd1, 24'd0, MODE_AUTO, 6'd0, 6'd0, 1'b1, 1'b0, '0);
        add_row(7'd1, 24'd0, MODE_AUTO, 6'd1, 6'd0, 1'b0, 1'b1, none_word());
        add_row(7'd64, 24'd255, MODE_AUTO, 6'd63, 6'd0, 1'b0, 1'b0, '0);
        add_row(7'd64, 24'd255, MODE_AUTO, 6'd0, 6'd0, 1'b0, 1'b0, '0);
        add_row(7'd64, 24'd255, MODE_AUTO, 6'd32, 6'd0, 1'b1, 1'b0, '0);
        add_row(7'd64, 24'd255, MODE_AUTO, 6'd1, 6'd0, 1'b0, 1'b0, '0);
        add_row(7'd64, 24'd256, MODE_AUTO, 6'd5, 6'd63, 1'b0, 1'b1, recv_word(6'd63, 30'd256));
        add_row(7'd64, 24'hFFFFFF, MODE_LINEAR, 6'd63, 6'd63, 1'b0, 1'b0, '0);
        add_row(7'd64, 24'hFFFFFF, MODE_LINEAR, 6'd63, 6'd63, 1'b1, 1'b0, '0);
        add_row(7'd64, 24'hFFFFFF, MODE_LINEAR, 6'd0, 6'd63, 1'b0, 1'b1,
                recv_word(6'd63, 30'hFFFFFF));
        add_row(7'd1, 24'd300, MODE_LINEAR, 6'd0, 6'd0, 1'b1, 1'b1, none_word());
        add_row(7'd0, 24'd300, MODE_LINEAR, 6'd0, 6'd0, 1'b1, 1'b1, none_word());
        add_row(7'd0, 24'd300, MODE_LINEAR, 6'd1, 6'd0, 1'b0, 1'b1, none_word());
        add_row(7'd0, 24'd300, MODE_LINEAR, 6'd0, 6'd0, 1'b0, 1'b0, '0);
        add_row(7'd127, 24'd100, MODE_BINOMIAL, 6'd63, 6'd0, 1'b0, 1'b0, '0);
        add_row(7'd100, 24'd100, MODE_BINOMIAL, 6'd20, 6'd63, 1'b1, 1'b0, '0);
        add_row(7'd13, 24'd200, MODE_SPARE, 6'd0, 6'd5, 1'b0, 1'b0, '0);
        add_row(7'd13, 24'd256, MODE_SPARE, 6'd7, 6'd5, 1'b0, 1'b1, recv_word(6'd5, 30'd256));
        add_row(7'd13, 24'hFFFFFF, MODE_BINOMIAL, 6'd5, 6'd5, 1'b0, 1'b0, '0);
        add_row(7'd13, 24'd0, MODE_BINOMIAL, 6'd5, 6'd5, 1'b1, 1'b0, '0);
        add_row(7'd13, 24'd0, MODE_BINOMIAL, 6'd12, 6'd5, 1'b0, 1'b0, '0);
        add_row(7'd32, 24'd0, MODE_BINOMIAL, 6'd0, 6'd40, 1'b0, 1'b1, none_word());
        add_row(7'd2, 24'd1, MODE_LINEAR, 6'd1, 6'd0, 1'b0, 1'b1, recv_word(6'd0, 30'd1));
        add_row(7'd2, 24'd7, MODE_BINOMIAL, 6'd0, 6'd1, 1'b1, 1'b0, '0);

        // Hold reset, then release it on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].grp_size != cfg_group_size || dir_rows[r].blk_bytes != cfg_block_bytes ||
                dir_rows[r].alg_mode != cfg_alg_mode) begin
                write_config(dir_rows[r].grp_size, dir_rows[r].blk_bytes, dir_rows[r].alg_mode);
            end
            send_request(dir_rows[r].my_rank, dir_rows[r].root_rank, dir_rows[r].in_place,
                         dir_rows[r].typed, dir_rows[r].entry);
            pace_sender();
        end

        // Random phases: pick a configuration, then mostly in-range requests
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       grp_r = 7'd64;
                1:       grp_r = COUNT_W'($urandom_range(65, 127));
                2:       grp_r = 7'd0;
                3:       grp_r = 7'd1;
                default: grp_r = COUNT_W'($urandom_range(2, 64));
            endcase
            if (ph == 0) grp_r = 7'd64;
            case ($urandom_range(0, 5))
                0:       blk_r = 24'd0;
                1:       blk_r = 24'd255;
                2:       blk_r = 24'd256;
                3:       blk_r = 24'hFFFFFF;
                4:       blk_r = BYTES_W'($urandom_range(0, 255));
                default: blk_r = BYTES_W'($urandom());
            endcase
            mode_r = MODE_W'($urandom_range(0, 3));
            write_config(grp_r, blk_r, mode_r);

            p_eff = (grp_r == 0) ? 1 : ((grp_r > MAX_RANKS) ? MAX_RANKS : int'(grp_r));
            for (int k = 0; k < PHASE_REQS; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    me_r   = RANK_W'($urandom());
                    root_r = RANK_W'($urandom());
                end else begin
                    root_r = RANK_W'($urandom_range(0, p_eff - 1));
                    me_r   = ($urandom_range(0, 3) == 0) ? root_r
                                                         : RANK_W'($urandom_range(0, p_eff - 1));
                end
                send_request(me_r, root_r, 1'($urandom_range(0, 1)), 1'b0, '0);
                pace_sender();
            end
        end

        wait_drained();
        if (error_count == 0 && sched_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
